### sv/gpr_pkg.sv
package gpr_pkg;

  localparam int unsigned PIN_COUNT = 16;
  localparam logic [15:0] PIN_MASK  = 16'((33'd1 << PIN_COUNT) - 33'd1);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [3:0] SEL_MODE     = 4'd0;
  localparam logic [3:0] SEL_TYPE     = 4'd1;
  localparam logic [3:0] SEL_SPEED    = 4'd2;
  localparam logic [3:0] SEL_PULL     = 4'd3;
  localparam logic [3:0] SEL_INPUT    = 4'd4;
  localparam logic [3:0] SEL_OUTPUT   = 4'd5;
  localparam logic [3:0] SEL_SETRESET = 4'd6;
  localparam logic [3:0] SEL_LOCK     = 4'd7;
  localparam logic [3:0] SEL_ALTLOW   = 4'd8;
  localparam logic [3:0] SEL_ALTHIGH  = 4'd9;

  localparam int unsigned LOCK_KEY_BIT = 16;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  reg_select;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } gpr_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] out_levels;
    logic        lock_active;
  } gpr_rsp_t;

  // Lock status: flag plus stored pin mask.
  typedef struct packed {
    logic        active;
    logic [15:0] pins;
  } gpr_lock_t;

  // 2 bits per pin.
  function automatic logic [31:0] spread2(logic [15:0] m);
    logic [31:0] r;
    r = '0;
    for (int p = 0; p < 16; p++) begin
      r[2*p +: 2] = {2{m[p]}};
    end
    return r;
  endfunction

  // 4 bits per pin, eight pins.
  function automatic logic [31:0] spread4(logic [7:0] m);
    logic [31:0] r;
    r = '0;
    for (int p = 0; p < 8; p++) begin
      r[4*p +: 4] = {4{m[p]}};
    end
    return r;
  endfunction

endpackage

### sv/gpr_lock.sv
module gpr_lock
  import gpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  logic [31:0] wdata_i,
  output gpr_lock_t   lock_q_o,
  output gpr_lock_t   lock_d_o
);

  localparam logic [1:0] KEY_IDLE  = 2'd0;
  localparam logic [1:0] KEY_CLEAR = 2'd1;
  localparam logic [1:0] KEY_FINAL = 2'd2;

  logic [1:0]  phase_q, phase_d;
  gpr_lock_t   lock_q, lock_d;
  logic [15:0] mask;
  logic        key;
  logic        same;

  assign mask = wdata_i[15:0] & PIN_MASK;
  assign key  = wdata_i[LOCK_KEY_BIT];
  assign same = (mask == lock_q.pins);

  always_comb begin
    phase_d = phase_q;
    lock_d  = lock_q;
    if (wr_i && !lock_q.active) begin
      unique case (phase_q)
        KEY_CLEAR: begin
          if (!key && same) begin
            phase_d = KEY_FINAL;
          end else begin
            lock_d.pins = mask;
            phase_d     = key ? KEY_CLEAR : KEY_IDLE;
          end
        end
        KEY_FINAL: begin
          if (key && same) begin
            lock_d.active = 1'b1;
            phase_d       = KEY_IDLE;
          end else begin
            lock_d.pins = mask;
            phase_d     = key ? KEY_CLEAR : KEY_IDLE;
          end
        end
        default: begin
          lock_d.pins = mask;
          phase_d     = key ? KEY_CLEAR : KEY_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= KEY_IDLE;
      lock_q  <= '0;
    end else begin
      phase_q <= phase_d;
      lock_q  <= lock_d;
    end
  end

  assign lock_q_o = lock_q;
  assign lock_d_o = lock_d;

endmodule

### sv/gpr_regs.sv
module gpr_regs
  import gpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     go_i,
  input  gpr_req_t req_i,
  output gpr_rsp_t rsp_o
);

  logic [31:0] mode_q, mode_d;
  logic [15:0] type_q, type_d;
  logic [31:0] speed_q, speed_d;
  logic [31:0] pull_q, pull_d;
  logic [31:0] alt_lo_q, alt_lo_d;
  logic [31:0] alt_hi_q, alt_hi_d;
  logic [15:0] latch_q, latch_d;

  gpr_lock_t   lock_q, lock_d;
  logic        wr;
  logic [15:0] ok;
  logic [31:0] m2;
  logic [31:0] m4_lo, m4_hi;
  logic [31:0] wd;
  logic [31:0] rd;

  assign wr = go_i && (req_i.cmd == CMD_WRITE);
  assign wd = req_i.write_data;

  gpr_lock u_lock (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr && (req_i.reg_select == SEL_LOCK)),
    .wdata_i  (wd),
    .lock_q_o (lock_q),
    .lock_d_o (lock_d)
  );

  // Pins whose configuration may still change.
  assign ok    = PIN_MASK & ~(lock_q.active ? lock_q.pins : 16'h0000);
  assign m2    = spread2(ok);
  assign m4_lo = spread4(ok[7:0]);
  assign m4_hi = spread4(ok[15:8]);

  always_comb begin
    mode_d   = mode_q;
    type_d   = type_q;
    speed_d  = speed_q;
    pull_d   = pull_q;
    alt_lo_d = alt_lo_q;
    alt_hi_d = alt_hi_q;
    latch_d  = latch_q;
    if (wr) begin
      unique case (req_i.reg_select)
        SEL_MODE:     mode_d   = (mode_q & ~m2) | (wd & m2);
        SEL_TYPE:     type_d   = (type_q & ~ok) | (wd[15:0] & ok);
        SEL_SPEED:    speed_d  = (speed_q & ~m2) | (wd & m2);
        SEL_PULL:     pull_d   = (pull_q & ~m2) | (wd & m2);
        SEL_OUTPUT:   latch_d  = wd[15:0] & PIN_MASK;
        // set wins over clear
        SEL_SETRESET: latch_d  = ((latch_q & ~(wd[31:16] & PIN_MASK)) | wd[15:0])
                                 & PIN_MASK;
        SEL_ALTLOW:   alt_lo_d = (alt_lo_q & ~m4_lo) | (wd & m4_lo);
        SEL_ALTHIGH:  alt_hi_d = (alt_hi_q & ~m4_hi) | (wd & m4_hi);
        default: ;
      endcase
    end
  end

  always_comb begin
    rd = '0;
    if (req_i.cmd == CMD_READ) begin
      unique case (req_i.reg_select)
        SEL_MODE:    rd = mode_q;
        SEL_TYPE:    rd = {16'h0000, type_q};
        SEL_SPEED:   rd = speed_q;
        SEL_PULL:    rd = pull_q;
        SEL_INPUT:   rd = {16'h0000, req_i.pin_levels & PIN_MASK};
        SEL_OUTPUT:  rd = {16'h0000, latch_q};
        SEL_LOCK:    rd = {15'h0000, lock_q.active, lock_q.pins};
        SEL_ALTLOW:  rd = alt_lo_q;
        SEL_ALTHIGH: rd = alt_hi_q;
        default:     rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      type_q   <= '0;
      speed_q  <= '0;
      pull_q   <= '0;
      alt_lo_q <= '0;
      alt_hi_q <= '0;
      latch_q  <= '0;
    end else if (go_i) begin
      mode_q   <= mode_d;
      type_q   <= type_d;
      speed_q  <= speed_d;
      pull_q   <= pull_d;
      alt_lo_q <= alt_lo_d;
      alt_hi_q <= alt_hi_d;
      latch_q  <= latch_d;
    end
  end

  assign rsp_o.read_data   = rd;
  assign rsp_o.out_levels  = latch_d;
  assign rsp_o.lock_active = lock_d.active;

endmodule

### sv/gpio_port_registers_unit.sv
// A transaction accepted at the input is first held in the request register and is
// loaded into the result register when it advances; the receiver takes it from there.
// Throughput: one register access per cycle; the register file updates in a
// single pass between the request register and the result register. The input
// stalls only while both stages are full and the receiver stalls.
// Reset (rst_ni low, async): all port registers, lock flag, lock mask and
// key phase clear to zero; both pipeline stages empty.
module gpio_port_registers_unit
  import gpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gpr_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gpr_rsp_t out_data_o
);

  // Request stage
  logic     req_valid_q;
  gpr_req_t req_q;

  // Result stage
  logic     rsp_valid_q;
  gpr_rsp_t rsp_q;

  gpr_rsp_t rsp;
  logic     advance;

  // A request moves on (and commits its register update) only when the
  // result register is empty or being drained this cycle.
  assign advance    = req_valid_q && (!rsp_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;

  gpr_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (advance),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_data_o  = rsp_q;

endmodule
